/* design/hgen_pkg.sv */
// hgen_pkg: shared types, widths, constants and trig tables of the helix tube
// vertex generator. No dependencies; imported by every design module.
package hgen_pkg;

  localparam int SEGMENTS_PER_COIL = 32;
  localparam int RING_SEGMENTS     = 16;
  localparam int MAX_COILS         = 16;

  localparam int RING_W     = 10;
  localparam int AROUND_W   = 5;
  localparam int COIL_W     = 5;
  localparam int POS_W      = 32;
  localparam int CORNER_W   = 14;
  localparam int RINGS_W    = 11;
  localparam int IDX_W      = 16;
  localparam int TRIG_W     = 18;
  localparam int HIDX_W     = $clog2(SEGMENTS_PER_COIL);
  localparam int TIDX_W     = $clog2(RING_SEGMENTS);
  localparam int RISE_W     = 44;
  localparam int SAT_W      = 42;
  localparam int RND_W      = 56;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 3 * POS_W + 4 * CORNER_W;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // pipeline: stage 1 decode, 4..8 divider, 9 output register
  localparam int NUM_STAGES  = 9;
  localparam int GEOM_STAGES = 8;
  localparam int ST_RISE     = 3;
  localparam int ST_DIV0     = 4;
  localparam int ST_ALIGN    = 8;
  localparam int DIV_STAGES  = ST_ALIGN - ST_DIV0 + 1;
  localparam int DIV_STEP    = 8;
  localparam int DIV_W       = DIV_STAGES * DIV_STEP;

  localparam logic signed [31:0] BOTTOM_RESET = 32'sd0;
  localparam logic signed [31:0] TOP_RESET    = 32'sd65536;
  localparam logic [COIL_W-1:0]  COIL_RESET   = 5'd1;
  localparam logic [30:0]        HELIX_RESET  = 31'd65536;
  localparam logic [30:0]        TUBE_RESET   = 31'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOTTOM  = 3'd0,
    REG_TOP     = 3'd1,
    REG_COILS   = 3'd2,
    REG_HELIX_R = 3'd3,
    REG_TUBE_R  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] bottom_height;
    logic signed [31:0] top_height;
    logic [COIL_W-1:0]  coil_count;
    logic [30:0]        helix_radius;
    logic [30:0]        tube_radius;
  } cfg_t;

  typedef struct packed {
    logic                range_error;
    logic                quad_valid;
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
    logic [CORNER_W-1:0] corner_d;
  } meta_t;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef trig_t [SEGMENTS_PER_COIL-1:0] helix_tab_t;
  typedef trig_t [RING_SEGMENTS-1:0]     tube_tab_t;

  localparam logic [63:0] SIN_A = 64'd1686629713;
  localparam logic [63:0] SIN_B = 64'd688904866;
  localparam logic [63:0] SIN_C = 64'd76016977;

  function automatic logic [63:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] v;
    logic [63:0] y;
    logic [63:0] r;
    x2 = (x * x) >> 16;
    v  = SIN_B - ((SIN_C * x2) >> 16);
    y  = SIN_A - ((v * x2) >> 16);
    r  = (y * x) >> 16;
    return (r + 64'd8192) >> 14;
  endfunction

  // phase: 2^18 per turn
  function automatic trig_t sine_phase(input logic [17:0] p);
    logic [63:0] x;
    logic [63:0] s;
    x = {48'd0, p[15:0]};
    s = p[16] ? quarter_sine(64'd65536 - x) : quarter_sine(x);
    return p[17] ? -TRIG_W'(s) : TRIG_W'(s);
  endfunction

  function automatic helix_tab_t helix_table(input logic want_cos);
    helix_tab_t tab;
    logic [17:0] p;
    for (int k = 0; k < SEGMENTS_PER_COIL; k++) begin
      p = 18'(((k % SEGMENTS_PER_COIL) << 18) / SEGMENTS_PER_COIL);
      if (want_cos) begin
        p = p + 18'd65536;
      end
      tab[k] = sine_phase(p);
    end
    return tab;
  endfunction

  function automatic tube_tab_t tube_table(input logic want_cos);
    tube_tab_t tab;
    logic [17:0] p;
    for (int k = 0; k < RING_SEGMENTS; k++) begin
      p = 18'(((k % RING_SEGMENTS) << 18) / RING_SEGMENTS);
      if (want_cos) begin
        p = p + 18'd65536;
      end
      tab[k] = sine_phase(p);
    end
    return tab;
  endfunction

  localparam helix_tab_t HELIX_COS = helix_table(1'b1);
  localparam helix_tab_t HELIX_SIN = helix_table(1'b0);
  localparam tube_tab_t  TUBE_COS  = tube_table(1'b1);
  localparam tube_tab_t  TUBE_SIN  = tube_table(1'b0);

  // >> 16, round to nearest, ties away from zero
  function automatic logic signed [RND_W-1:0] rnd16(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] bias;
    bias = v[RND_W-1] ? RND_W'(32767) : RND_W'(32768);
    return (v + bias) >>> 16;
  endfunction

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > SAT_W'(64'sd2147483647)) begin
      return 32'sh7FFFFFFF;
    end else if (v < SAT_W'(-64'sd2147483648)) begin
      return 32'sh80000000;
    end
    return v[POS_W-1:0];
  endfunction

endpackage

/* design/hgen_regs.sv */
// hgen_regs: configuration register file written through the cfg channel.
// Depends on hgen_pkg.
module hgen_regs import hgen_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bottom_height <= BOTTOM_RESET;
      cfg_r.top_height    <= TOP_RESET;
      cfg_r.coil_count    <= COIL_RESET;
      cfg_r.helix_radius  <= HELIX_RESET;
      cfg_r.tube_radius   <= TUBE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOTTOM:  cfg_r.bottom_height <= cfg_data;
        REG_TOP:     cfg_r.top_height    <= cfg_data;
        REG_COILS:   cfg_r.coil_count    <= cfg_data[COIL_W-1:0];
        REG_HELIX_R: cfg_r.helix_radius  <= cfg_data[30:0];
        REG_TUBE_R:  cfg_r.tube_radius   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/hgen_div.sv */
// hgen_div: pipelined restoring divider by the coil count, DIV_STEP quotient
// bits per stage. Depends on hgen_pkg.
module hgen_div import hgen_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [DIV_W-1:0]      dividend,
  input  logic [COIL_W-1:0]     divisor,
  output logic [DIV_W-1:0]      quotient
);

  logic [DIV_W-1:0]  acc_r [DIV_STAGES];
  logic [COIL_W-1:0] rem_r [DIV_STAGES-1];
  logic [COIL_W-1:0] dvs_r [DIV_STAGES-1];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_W-1:0]  acc_in;
    logic [COIL_W-1:0] rem_in;
    logic [COIL_W-1:0] dvs_in;
    logic [DIV_W-1:0]  acc_nxt;
    logic [COIL_W-1:0] rem_nxt;

    if (s == 0) begin : g_first
      assign acc_in = dividend;
      assign rem_in = '0;
      assign dvs_in = divisor;
    end else begin : g_next
      assign acc_in = acc_r[s-1];
      assign rem_in = rem_r[s-1];
      assign dvs_in = dvs_r[s-1];
    end

    always_comb begin
      logic [COIL_W:0] trial;
      acc_nxt = acc_in;
      rem_nxt = rem_in;
      for (int b = 0; b < DIV_STEP; b++) begin
        trial   = {rem_nxt, acc_nxt[DIV_W-1]};
        acc_nxt = {acc_nxt[DIV_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs_in}) begin
          acc_nxt[0] = 1'b1;
          trial      = trial - {1'b0, dvs_in};
        end
        rem_nxt = trial[COIL_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        acc_r[s] <= acc_nxt;
      end
    end

    if (s < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[s]) begin
          rem_r[s] <= rem_nxt;
          dvs_r[s] <= dvs_in;
        end
      end
    end
  end

  assign quotient = acc_r[DIV_STAGES-1];

endmodule

/* design/hgen_geom.sv */
// hgen_geom: trig lookup and multiply/round pipeline for x, z and the tube
// part of the height. Depends on hgen_pkg.
module hgen_geom import hgen_pkg::*; (
  input  logic                    clk,
  input  logic [GEOM_STAGES:1]    en,
  input  cfg_t                    cfg,
  input  logic [RING_W-1:0]       ring_number,
  input  logic [AROUND_W-1:0]     around_number,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_z,
  output logic signed [34:0]      y_base
);

  trig_t ct_s1_r, st_s1_r, cp_s1_r, sp_s1_r;
  trig_t ct_s2_r, st_s2_r, ct_s3_r, st_s3_r, ct_s4_r, st_s4_r;
  logic signed [49:0] prc_s2_r, psp_s2_r;
  logic signed [33:0] rc_s3_r, ys_s3_r;
  logic signed [34:0] xs_s4_r, zs_s4_r;
  logic signed [34:0] yb_s4_r, yb_s5_r, yb_s6_r, yb_s7_r, yb_s8_r;
  logic signed [52:0] px_s5_r, pz_s5_r;
  logic signed [36:0] rx_s6_r, rz_s6_r;
  logic signed [POS_W-1:0] sx_s7_r, sz_s7_r, sx_s8_r, sz_s8_r;

  trig_t ct_nxt, st_nxt, cp_nxt, sp_nxt;
  logic signed [31:0] tube_r_s, helix_r_s;

  assign tube_r_s  = $signed({1'b0, cfg.tube_radius});
  assign helix_r_s = $signed({1'b0, cfg.helix_radius});

  always_comb begin
    ct_nxt = HELIX_COS[HIDX_W'(ring_number % SEGMENTS_PER_COIL)];
    st_nxt = HELIX_SIN[HIDX_W'(ring_number % SEGMENTS_PER_COIL)];
    cp_nxt = TUBE_COS[TIDX_W'(around_number % RING_SEGMENTS)];
    sp_nxt = TUBE_SIN[TIDX_W'(around_number % RING_SEGMENTS)];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ct_s1_r <= ct_nxt;
      st_s1_r <= st_nxt;
      cp_s1_r <= cp_nxt;
      sp_s1_r <= sp_nxt;
    end
    if (en[2]) begin
      prc_s2_r <= tube_r_s * cp_s1_r;
      psp_s2_r <= tube_r_s * sp_s1_r;
      ct_s2_r  <= ct_s1_r;
      st_s2_r  <= st_s1_r;
    end
    if (en[3]) begin
      rc_s3_r <= 34'(rnd16(RND_W'(prc_s2_r)));
      ys_s3_r <= 34'(rnd16(RND_W'(psp_s2_r)));
      ct_s3_r <= ct_s2_r;
      st_s3_r <= st_s2_r;
    end
    if (en[4]) begin
      xs_s4_r <= 35'(helix_r_s) + 35'(rc_s3_r);
      zs_s4_r <= 35'(helix_r_s) - 35'(rc_s3_r);
      yb_s4_r <= 35'($signed(cfg.bottom_height)) + 35'(ys_s3_r);
      ct_s4_r <= ct_s3_r;
      st_s4_r <= st_s3_r;
    end
    if (en[5]) begin
      px_s5_r <= xs_s4_r * ct_s4_r;
      pz_s5_r <= zs_s4_r * st_s4_r;
      yb_s5_r <= yb_s4_r;
    end
    if (en[6]) begin
      rx_s6_r <= 37'(rnd16(RND_W'(px_s5_r)));
      rz_s6_r <= 37'(rnd16(RND_W'(pz_s5_r)));
      yb_s6_r <= yb_s5_r;
    end
    if (en[7]) begin
      sx_s7_r <= sat32(SAT_W'(rx_s6_r));
      sz_s7_r <= sat32(SAT_W'(rz_s6_r));
      yb_s7_r <= yb_s6_r;
    end
    if (en[8]) begin
      sx_s8_r <= sx_s7_r;
      sz_s8_r <= sz_s7_r;
      yb_s8_r <= yb_s7_r;
    end
  end

  assign pos_x  = sx_s8_r;
  assign pos_z  = sz_s8_r;
  assign y_base = yb_s8_r;

endmodule

/* design/helix_tube_vertex_generator_top.sv */
// helix_tube_vertex_generator_top: stream wrapper, stage control, index and
// height-rise path. Depends on hgen_pkg, hgen_regs, hgen_geom, hgen_div.
//
// Usage:
//   in_*  : one item per vertex, tdata = {around_number, ring_number}.
//   out_* : one result item per input item, in order; tdata carries the
//           position and the four quad corners, tuser the two flags.
//   cfg_* : register writes, index 0..4; cfg_ready is always high. Write
//           only while no item is in flight.
// Nine register stages: an item accepted into stage 1 raises out_tvalid once
// it reaches the stage 9 output register and can leave from there; throughput
// is one item per cycle while out_tready stays high. The latency is set by
// the five-stage coil-count divider of the height rise, which runs beside the
// two multiply/round steps of the x and z path.
// Reset clears every stage valid bit and loads the register defaults.
// When the receiver stalls, the output register holds its item and the
// stages behind it keep moving until they fill; in_tready drops only when
// all nine stages hold an item and out_tready is low.
module helix_tube_vertex_generator_top import hgen_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [9:0] ring_number, [14:10] around_number, [15] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [109:96] corner_a,
  // [123:110] corner_b, [137:124] corner_c, [151:138] corner_d
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] quad_valid, [1] range_error
  output logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic [NUM_STAGES:1] v_r;
  logic [NUM_STAGES:1] en_w;

  logic [RING_W-1:0]   ring_number;
  logic [AROUND_W-1:0] around_number;

  logic signed [POS_W-1:0] geo_x, geo_z;
  logic signed [34:0]      geo_yb;
  logic [DIV_W-1:0]        quotient;

  meta_t meta_r [1:ST_ALIGN];
  logic  neg_r  [ST_RISE:ST_ALIGN];

  logic [COIL_W-1:0]        coils_s1_r, coils_s2_r, dvs_s3_r;
  logic signed [32:0]       diff_s1_r;
  logic [RING_W-1:0]        ring_s1_r;
  logic signed [RISE_W-1:0] prise_s2_r;
  logic [DIV_W-1:0]         dvd_s3_r;

  logic signed [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  meta_t                   meta_o_r;

  logic [COIL_W-1:0]   coils_nxt;
  logic [RINGS_W-1:0]  rings;
  logic [IDX_W-1:0]    idx_full;
  meta_t               meta_nxt;
  logic                sgn;
  logic [RISE_W-1:0]   mag;
  logic [RISE_W-1:0]   offs;
  logic signed [SAT_W-1:0] y_sum;

  assign ring_number   = in_tdata[RING_W-1:0];
  assign around_number = in_tdata[RING_W +: AROUND_W];

  hgen_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hgen_geom u_geom (
    .clk           (clk),
    .en            (en_w[GEOM_STAGES:1]),
    .cfg           (cfg),
    .ring_number   (ring_number),
    .around_number (around_number),
    .pos_x         (geo_x),
    .pos_z         (geo_z),
    .y_base        (geo_yb)
  );

  hgen_div u_div (
    .clk      (clk),
    .en       (en_w[ST_ALIGN:ST_DIV0]),
    .dividend (dvd_s3_r),
    .divisor  (dvs_s3_r),
    .quotient (quotient)
  );

  // stage k loads when it is empty or the stage after it loads
  always_comb begin
    en_w[NUM_STAGES] = !v_r[NUM_STAGES] || out_tready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en_w[k] = !v_r[k] || en_w[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en_w[1]) begin
        v_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en_w[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready  = en_w[1];
  assign out_tvalid = v_r[NUM_STAGES];

  // stage 1: range check and corner indices
  always_comb begin
    if (cfg.coil_count == '0) begin
      coils_nxt = COIL_W'(1);
    end else if (cfg.coil_count > COIL_W'(MAX_COILS)) begin
      coils_nxt = COIL_W'(MAX_COILS);
    end else begin
      coils_nxt = cfg.coil_count;
    end
    rings    = RINGS_W'(coils_nxt) * RINGS_W'(SEGMENTS_PER_COIL);
    idx_full = IDX_W'(ring_number) * IDX_W'(RING_SEGMENTS + 1) + IDX_W'(around_number);
    meta_nxt.range_error = (RINGS_W'(ring_number) > rings) ||
                           (around_number > AROUND_W'(RING_SEGMENTS));
    meta_nxt.quad_valid  = !meta_nxt.range_error && (RINGS_W'(ring_number) < rings) &&
                           (around_number < AROUND_W'(RING_SEGMENTS));
    meta_nxt.corner_a = meta_nxt.range_error ? '0 : CORNER_W'(idx_full);
    meta_nxt.corner_b = '0;
    meta_nxt.corner_c = '0;
    meta_nxt.corner_d = '0;
    if (meta_nxt.quad_valid) begin
      meta_nxt.corner_b = CORNER_W'(idx_full) + CORNER_W'(RING_SEGMENTS + 1);
      meta_nxt.corner_c = CORNER_W'(idx_full) + CORNER_W'(1);
      meta_nxt.corner_d = CORNER_W'(idx_full) + CORNER_W'(RING_SEGMENTS + 2);
    end
  end

  // stage 3: |rise| plus half the divisor, pre-shifted by the segment count
  always_comb begin
    sgn  = prise_s2_r[RISE_W-1];
    mag  = (prise_s2_r ^ {RISE_W{sgn}}) + RISE_W'(sgn);
    offs = RISE_W'(coils_s2_r) * RISE_W'(SEGMENTS_PER_COIL / 2);
  end

  always_ff @(posedge clk) begin
    if (en_w[1]) begin
      meta_r[1]  <= meta_nxt;
      coils_s1_r <= coils_nxt;
      ring_s1_r  <= ring_number;
      diff_s1_r  <= 33'($signed(cfg.top_height)) - 33'($signed(cfg.bottom_height));
    end
    if (en_w[2]) begin
      prise_s2_r <= diff_s1_r * $signed({1'b0, ring_s1_r});
      coils_s2_r <= coils_s1_r;
    end
    if (en_w[ST_RISE]) begin
      dvd_s3_r       <= DIV_W'((mag + offs) >> HIDX_W);
      dvs_s3_r       <= coils_s2_r;
      neg_r[ST_RISE] <= sgn;
    end
    for (int k = 2; k <= ST_ALIGN; k++) begin
      if (en_w[k]) begin
        meta_r[k] <= meta_r[k-1];
      end
    end
    for (int k = ST_RISE + 1; k <= ST_ALIGN; k++) begin
      if (en_w[k]) begin
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  // stage 9: signed rise, height sum and output register
  always_comb begin
    y_sum = SAT_W'(geo_yb) +
            SAT_W'($signed({neg_r[ST_ALIGN], quotient ^ {DIV_W{neg_r[ST_ALIGN]}}})) +
            SAT_W'(neg_r[ST_ALIGN]);
  end

  always_ff @(posedge clk) begin
    if (en_w[NUM_STAGES]) begin
      meta_o_r <= meta_r[ST_ALIGN];
      if (meta_r[ST_ALIGN].range_error) begin
        pos_x_r <= '0;
        pos_y_r <= '0;
        pos_z_r <= '0;
      end else begin
        pos_x_r <= geo_x;
        pos_y_r <= sat32(y_sum);
        pos_z_r <= geo_z;
      end
    end
  end

  assign out_tdata = {meta_o_r.corner_d, meta_o_r.corner_c, meta_o_r.corner_b,
                      meta_o_r.corner_a, pos_z_r, pos_y_r, pos_x_r};
  assign out_tuser = {meta_o_r.range_error, meta_o_r.quad_valid};

endmodule

/* design/hgen_chk.sv */
// hgen_chk: port-level assertions for the helix tube vertex generator, bound
// to helix_tube_vertex_generator_top. Depends on hgen_pkg.
module hgen_chk import hgen_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  logic [CORNER_W-1:0] ca, cb, cc, cd;

  assign ca = out_tdata[3*POS_W +: CORNER_W];
  assign cb = out_tdata[3*POS_W + CORNER_W +: CORNER_W];
  assign cc = out_tdata[3*POS_W + 2*CORNER_W +: CORNER_W];
  assign cd = out_tdata[3*POS_W + 3*CORNER_W +: CORNER_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output item changed");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input blocked without an output stall");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && out_tdata == '0)
    else $error("range error item carries data");

  a_quad_corners: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      cb == ca + CORNER_W'(RING_SEGMENTS + 1) && cc == ca + CORNER_W'(1) &&
      cd == cb + CORNER_W'(1))
    else $error("quad corners inconsistent");

  a_no_quad_corners: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> cb == '0 && cc == '0 && cd == '0)
    else $error("corners set without a quad");

endmodule

bind helix_tube_vertex_generator_top hgen_chk u_hgen_chk (.*);
